// ----- rtl/rcsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcsc_pkg;

  // Fixed field widths.
  localparam int CHAN_W  = 11;
  localparam int CNT_W   = 16;
  localparam int OP_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int SKIP_ENTRIES_DEFAULT = 16;
  localparam int MAX_CHANNEL_DEFAULT  = 1024;

  // Countdown loads and settling window bounds.
  localparam logic [CNT_W-1:0] SHORT_PAUSE_TICKS = 16'd500;
  localparam logic [CNT_W-1:0] STEP_TICKS        = 16'd30;
  localparam logic [CNT_W-1:0] SETTLE_TICKS      = 16'd1;
  localparam logic [CNT_W-1:0] QUICK_PASS_TICKS  = 16'd1;
  localparam logic [CNT_W-1:0] PAUSE_DELAY_RESET = 16'd5000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_ONCE  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_START = 3'd0,
    OP_TICK  = 3'd1,
    OP_SKIP  = 3'd2,
    OP_ADV   = 3'd3,
    OP_STOP  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    PH_SCAN   = 2'd0,
    PH_SHORT  = 2'd1,
    PH_PAUSED = 2'd2
  } phase_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic              carrier_detected;
    logic              digital_active;
    logic              audio_active;
    logic [CHAN_W-1:0] next_channel;
    logic              next_skip_flag;
  } in_item_t;

  typedef struct packed {
    logic              scan_active;
    logic [1:0]        scan_phase;
    logic              advanced;
    logic [CHAN_W-1:0] current_channel;
  } out_item_t;

  // One skip list entry held by a cell.
  typedef struct packed {
    logic              vld;
    logic [CHAN_W-1:0] chan;
  } skip_ent_t;

  // Search token that walks down the chain of cells.
  typedef struct packed {
    logic              vld;
    logic [CHAN_W-1:0] key;
    logic              hit;
  } search_tok_t;

  // List control broadcast to every cell.
  typedef struct packed {
    logic clr;
    logic ins;
  } skip_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/rcsc_skip_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcsc_skip_cell
  import rcsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire skip_ctl_t   ctl,
  input  wire skip_ent_t   ent_in,
  output skip_ent_t        ent_out,
  input  wire search_tok_t tok_in,
  output search_tok_t      tok_out
);

  skip_ent_t   ent;
  search_tok_t tok;
  logic        match;

  // The entry matches the passing key when it holds a valid channel equal to that key.
  assign match = ent.vld && (ent.chan == tok_in.key);

  // Entry storage: cleared on reset or start, shifted one place on an insert.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      ent.vld <= 1'b0;
    end else if (ctl.ins) begin
      ent.vld <= ent_in.vld;
    end
    if (ctl.ins) begin
      ent.chan <= ent_in.chan;
    end
  end

  // The search token moves one cell per cycle and collects a hit.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.vld <= 1'b0;
    end else begin
      tok.vld <= tok_in.vld;
    end
    tok.key <= tok_in.key;
    tok.hit <= tok_in.hit | (tok_in.vld & match);
  end

  assign ent_out = ent;
  assign tok_out = tok;

endmodule

`default_nettype wire

// ----- rtl/radio_channel_scan_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel scan controller, stepped by one request per millisecond tick.
// The input channel carries an opcode (start, tick, skip key, manual
// advance, stop) with the receiver status and the channel the host offers
// next. Every request returns exactly one result on the output channel:
// scan running, scan phase, an advanced flag and the channel now tuned.
// Two configuration registers (pause delay, pause-once mode) are written
// through a simple write port; the user must write them only while the block is idle, which the block does not enforce.
// A result passes through the holding stage and then the output register. A
// tick that advances to a channel without a skip flag searches the skip list,
// a row of SKIP_ENTRIES cells that a search token walks one cell per cycle, so
// no next request is taken until the token leaves the last cell; every other
// request frees the input once its result has left the holding stage.
// A result register and a holding stage sit between the two sides, so one
// further request is taken while a result waits under stall; the input
// stalls whenever the holding stage is full or a search runs.
// Reset stops the scan, sets the phase to scanning, clears the countdown,
// tuned channel and skip list, and loads the register defaults.
module radio_channel_scan_controller
  import rcsc_pkg::*;
#(
  parameter int SKIP_ENTRIES = SKIP_ENTRIES_DEFAULT,
  parameter int MAX_CHANNEL  = MAX_CHANNEL_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LIM_W = CHAN_W + 2;
  localparam logic [LIM_W-1:0] CHAN_LIMIT = LIM_W'(MAX_CHANNEL);

  // Configuration registers.
  logic [CNT_W-1:0]  pause_delay_ticks;
  logic              pause_once_mode;

  // Scan state.
  logic              active_flag;
  phase_t            phase;
  logic [CNT_W-1:0]  countdown;
  logic [CHAN_W-1:0] tuned_channel;
  logic              busy;

  logic              active_flag_next;
  phase_t            phase_next;
  logic [CNT_W-1:0]  countdown_next;
  logic [CHAN_W-1:0] tuned_channel_next;
  logic              adv;
  logic              launch;
  skip_ctl_t         ctl;

  logic              in_acc;
  logic [CHAN_W-1:0] next_clamped;

  // Holding stage and output register.
  logic              pend_valid;
  out_item_t         pend_data;
  logic              out_load;

  // Chain wiring.
  search_tok_t       tok [SKIP_ENTRIES+1];
  skip_ent_t         ent [SKIP_ENTRIES+1];
  search_tok_t       tail;

  assign in_stall = busy | pend_valid;
  assign in_acc   = in_valid & ~in_stall;
  assign out_load = pend_valid & (~out_valid | ~out_stall);
  assign tail     = tok[SKIP_ENTRIES];

  // Saturate the offered channel to the highest channel number.
  assign next_clamped = ({2'b00, in_data.next_channel} > CHAN_LIMIT) ?
                        CHAN_LIMIT[CHAN_W-1:0] : in_data.next_channel;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_delay_ticks <= PAUSE_DELAY_RESET;
      pause_once_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAUSE_DELAY: pause_delay_ticks <= cfg_data;
        REG_PAUSE_ONCE:  pause_once_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode one request into the next scan state.
  always_comb begin
    active_flag_next   = active_flag;
    phase_next         = phase;
    countdown_next     = countdown;
    tuned_channel_next = tuned_channel;
    adv                = 1'b0;
    launch             = 1'b0;
    ctl                = '0;
    if (in_acc) begin
      unique case (in_data.opcode)
        OP_START: begin
          ctl.clr          = 1'b1;
          active_flag_next = 1'b1;
          countdown_next   = SHORT_PAUSE_TICKS;
          phase_next       = PH_SCAN;
        end
        OP_TICK: begin
          if (active_flag) begin
            // Look for activity inside the settling window.
            if (phase_next == PH_SCAN && countdown_next > QUICK_PASS_TICKS &&
                countdown_next < (STEP_TICKS - SETTLE_TICKS)) begin
              if (in_data.digital_active) begin
                phase_next     = PH_PAUSED;
                countdown_next = pause_delay_ticks;
              end else if (in_data.carrier_detected) begin
                phase_next     = PH_SHORT;
                countdown_next = SHORT_PAUSE_TICKS;
              end
            end
            // Audio turns a short pause into a full pause and, unless in pause-once mode, restarts a full pause.
            if ((phase_next == PH_PAUSED && !pause_once_mode) ||
                phase_next == PH_SHORT) begin
              if (in_data.audio_active) begin
                countdown_next = pause_delay_ticks;
                phase_next     = PH_PAUSED;
              end
            end
            // Count down, or advance once the countdown has run out.
            if (countdown_next != '0) begin
              countdown_next = countdown_next - 1'b1;
            end else begin
              tuned_channel_next = next_clamped;
              adv                = 1'b1;
              phase_next         = PH_SCAN;
              if (in_data.next_skip_flag) begin
                countdown_next = QUICK_PASS_TICKS;
              end else begin
                countdown_next = STEP_TICKS;
                launch         = 1'b1;
              end
            end
          end
        end
        OP_SKIP: begin
          if (phase == PH_PAUSED) begin
            ctl.ins        = 1'b1;
            countdown_next = QUICK_PASS_TICKS;
            phase_next     = PH_SCAN;
          end else begin
            active_flag_next = 1'b0;
          end
        end
        OP_ADV: begin
          tuned_channel_next = next_clamped;
          adv                = 1'b1;
          countdown_next     = SHORT_PAUSE_TICKS;
          phase_next         = PH_SCAN;
        end
        OP_STOP: begin
          active_flag_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Scan state registers; a search hit shortens the countdown afterwards.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag   <= 1'b0;
      phase         <= PH_SCAN;
      countdown     <= '0;
      tuned_channel <= '0;
      busy          <= 1'b0;
    end else begin
      active_flag   <= active_flag_next;
      phase         <= phase_next;
      tuned_channel <= tuned_channel_next;
      if (in_acc) begin
        countdown <= countdown_next;
      end else if (tail.vld && tail.hit) begin
        countdown <= QUICK_PASS_TICKS;
      end
      if (launch) begin
        busy <= 1'b1;
      end else if (tail.vld) begin
        busy <= 1'b0;
      end
    end
  end

  // Head of the chain: a new entry and a new search token.
  assign ent[0].vld  = 1'b1;
  assign ent[0].chan = tuned_channel;
  assign tok[0].vld  = launch;
  assign tok[0].key  = next_clamped;
  assign tok[0].hit  = 1'b0;

  // Row of skip list cells.
  for (genvar i = 0; i < SKIP_ENTRIES; i++) begin : g_cell
    rcsc_skip_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .ent_in  (ent[i]),
      .ent_out (ent[i+1]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Holding stage: takes the result of each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (out_load) begin
      pend_valid <= 1'b0;
    end
    if (in_acc) begin
      pend_data.scan_active     <= active_flag_next;
      pend_data.scan_phase      <= phase_next;
      pend_data.advanced        <= adv;
      pend_data.current_channel <= tuned_channel_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= pend_data;
    end
  end

endmodule

`default_nettype wire
